// ===== rtl/lsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared types and codes of the LRU stack distance miss counter.
// ----------------------------------------------------------------------------
package lsd_pkg;

	localparam int MAX_SIZES = 4;
	localparam int SIZE_BITS = 7;
	localparam int CNT_BITS  = 32;

	typedef enum logic [1:0] {
		OP_ACCESS = 2'd0,
		OP_RANGE  = 2'd1,
		OP_REPORT = 2'd2,
		OP_NONE   = 2'd3
	} lsd_op_t;

	typedef enum logic [2:0] {
		REG_SIZES_IN_USE = 3'd0,
		REG_CACHE_SIZE_0 = 3'd1,
		REG_CACHE_SIZE_1 = 3'd2,
		REG_CACHE_SIZE_2 = 3'd3,
		REG_CACHE_SIZE_3 = 3'd4
	} lsd_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_TAIL
	} lsd_stack_state_t;

	typedef enum logic [1:0] {
		TP_IDLE,
		TP_ISSUE,
		TP_WAIT,
		TP_REPORT
	} lsd_top_state_t;

	typedef struct packed {
		logic done;
		logic hit;
	} lsd_resp_t;

endpackage

// ===== rtl/lsd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lsd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/lsd_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_stack
// LRU stack in RAM: walks from the top, shifting entries down by one until
// the address is found or the filled part ends, then reports a hit with its distance, or a miss.
// ----------------------------------------------------------------------------
module lsd_stack
	import lsd_pkg::*;
#(
	parameter int STACK_DEPTH = 64,
	parameter int ADDR_BITS   = 24,
	parameter int DW          = $clog2(STACK_DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [ADDR_BITS-1:0] addr,
	output lsd_resp_t            resp,
	output logic [DW-1:0]        stk_dist
);

	localparam int IW = $clog2(STACK_DEPTH);

	lsd_stack_state_t state_q, state_d;
	logic [DW-1:0]        fill_q, fill_d;
	logic [IW-1:0]        idx_q, idx_d;
	logic [ADDR_BITS-1:0] addr_q, addr_d;
	logic [ADDR_BITS-1:0] carry_q, carry_d;
	logic                 we;
	logic [IW-1:0]        waddr, raddr;
	logic [ADDR_BITS-1:0] wdata, rdata;
	logic [DW-1:0]        next_pos;

	lsd_ram #(.WIDTH(ADDR_BITS), .DEPTH(STACK_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		addr_q  <= addr_d;
		carry_q <= carry_d;
	end

	assign next_pos = DW'(idx_q) + DW'(1);
	assign stk_dist = next_pos;

	always_comb begin
		state_d = state_q;
		fill_d  = fill_q;
		idx_d   = idx_q;
		addr_d  = addr_q;
		carry_d = carry_q;
		we      = 1'b0;
		waddr   = idx_q;
		wdata   = carry_q;
		raddr   = '0;
		resp    = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					addr_d  = addr;
					carry_d = addr;
					idx_d   = '0;
					if (fill_q == '0) begin
						state_d = ST_TAIL;
					end else begin
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				we = 1'b1;
				if (rdata == addr_q) begin
					resp.done = 1'b1;
					resp.hit  = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					carry_d = rdata;
					if (next_pos == fill_q) begin
						if (fill_q != DW'(STACK_DEPTH)) begin
							idx_d   = IW'(next_pos);
							state_d = ST_TAIL;
						end else begin
							resp.done = 1'b1;
							state_d   = ST_IDLE;
						end
					end else begin
						raddr = IW'(next_pos);
						idx_d = IW'(next_pos);
					end
				end
			end
			ST_TAIL: begin
				we        = 1'b1;
				fill_d    = fill_q + DW'(1);
				resp.done = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DW'(STACK_DEPTH))
		else $error("stack fill beyond depth");
	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> fill_q != '0 && DW'(idx_q) < fill_q)
		else $error("walk outside filled entries");
	a_tail_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TAIL |=> fill_q == $past(fill_q) + DW'(1))
		else $error("tail write did not grow stack");

endmodule

// ===== rtl/lru_stack_distance_miss_counter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_stack_distance_miss_counter_unit
// Miss counts of several LRU cache sizes at once from LRU stack distance.
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// s_*      in         s_tvalid/s_tready   s_tdata: opcode, address, stride, count
// m_*      out        m_tvalid/m_tready   m_tdata: miss_count, m_tuser, m_tlast
// cfg_*    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// an access walks the stack from the top, as the stack RAM yields one entry
// per cycle, until a hit at stack position d; on a miss it walks all f filled
// entries and pushes the address, dropping the last once the stack is full
// a range item runs count accesses from address by stride, count zero none
// a report sends one word per size in use; s_tready is low until an item is done
// reset empties the stack and clears counters; no clearing pass
// the output register holds a result under stall without losing it
// ----------------------------------------------------------------------------
module lru_stack_distance_miss_counter_unit
	import lsd_pkg::*;
#(
	parameter int STACK_DEPTH = 64,
	parameter int NUM_SIZES   = 4,
	parameter int ADDR_BITS   = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // opcode[1:0], address[25:2], stride[49:26], count[65:50]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // miss_count[31:0]
	output logic [1:0]  m_tuser,   // size_index[1:0]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int NC = (NUM_SIZES < MAX_SIZES) ? NUM_SIZES : MAX_SIZES;
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int CW = (DW > SIZE_BITS) ? DW : SIZE_BITS;

	lsd_top_state_t       state_q, state_d;
	logic [2:0]           siu_q;
	logic [SIZE_BITS-1:0] size_q [NC];
	logic [CNT_BITS-1:0]  cnt_q [NC];
	logic [ADDR_BITS-1:0] cur_q, stride_q;
	logic [16:0]          remain_q;
	logic [1:0]           k_q;
	logic [2:0]           n_act;
	lsd_resp_t            resp;
	logic [DW-1:0]        stk_dist;
	logic                 accept, start, out_load, out_last;
	lsd_op_t              op;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == TP_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign op        = lsd_op_t'(s_tdata[1:0]);
	assign start     = (state_q == TP_ISSUE);

	always_comb begin
		if (siu_q == 3'd0) begin
			n_act = 3'd1;
		end else if (siu_q > 3'(NC)) begin
			n_act = 3'(NC);
		end else begin
			n_act = siu_q;
		end
	end

	assign out_load = (state_q == TP_REPORT) && (!m_tvalid || m_tready);
	assign out_last = (3'(k_q) + 3'd1 == n_act);

	lsd_stack #(.STACK_DEPTH(STACK_DEPTH), .ADDR_BITS(ADDR_BITS)) u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.addr     (cur_q),
		.resp     (resp),
		.stk_dist (stk_dist)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			TP_IDLE: begin
				if (accept) begin
					case (op)
						OP_ACCESS: state_d = TP_ISSUE;
						OP_RANGE:  state_d = (s_tdata[65:50] != 16'd0) ? TP_ISSUE : TP_IDLE;
						OP_REPORT: state_d = TP_REPORT;
						default:   state_d = TP_IDLE;
					endcase
				end
			end
			TP_ISSUE: state_d = TP_WAIT;
			TP_WAIT: begin
				if (resp.done) begin
					state_d = (remain_q == 17'd1) ? TP_IDLE : TP_ISSUE;
				end
			end
			TP_REPORT: begin
				if (out_load && out_last) begin
					state_d = TP_IDLE;
				end
			end
			default: state_d = TP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= TP_IDLE;
			siu_q    <= 3'd1;
			remain_q <= '0;
			k_q      <= '0;
			m_tvalid <= 1'b0;
			for (int i = 0; i < NC; i++) begin
				size_q[i] <= SIZE_BITS'(1);
				cnt_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SIZES_IN_USE) begin
					siu_q <= cfg_data[2:0];
				end
				for (int i = 0; i < NC; i++) begin
					if (cfg_index == 3'(i + 1)) begin
						size_q[i] <= cfg_data[SIZE_BITS-1:0];
					end
				end
			end
			if (accept) begin
				remain_q <= (op == OP_RANGE) ? {1'b0, s_tdata[65:50]} : 17'd1;
				k_q      <= '0;
			end
			if (state_q == TP_WAIT && resp.done) begin
				remain_q <= remain_q - 17'd1;
				for (int i = 0; i < NC; i++) begin
					if (3'(i) < n_act && (!resp.hit || CW'(size_q[i]) < CW'(stk_dist))
						&& cnt_q[i] != '1) begin
						cnt_q[i] <= cnt_q[i] + CNT_BITS'(1);
					end
				end
			end
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (out_load) begin
				m_tvalid <= 1'b1;
				k_q      <= k_q + 2'd1;
				if (out_last) begin
					for (int i = 0; i < NC; i++) begin
						cnt_q[i] <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q    <= ADDR_BITS'(s_tdata[25:2]);
			stride_q <= ADDR_BITS'(s_tdata[49:26]);
		end else if (state_q == TP_WAIT && resp.done) begin
			cur_q <= cur_q + stride_q;
		end
		if (out_load) begin
			m_tuser <= k_q;
			m_tdata <= cnt_q[k_q];
			m_tlast <= out_last;
		end
	end

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == TP_WAIT || state_q == TP_ISSUE) |-> !s_tready)
		else $error("input accepted during access");
	a_report_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && out_last |=> cnt_q[0] == '0 && state_q == TP_IDLE)
		else $error("report did not clear counters");
	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == TP_REPORT |-> 3'(k_q) < n_act)
		else $error("report index beyond sizes in use");

endmodule
